FILE: design/sbd_pkg.sv
// shared types and constants for the snappy block decoder
// no dependencies; imported by every design file
package sbd_pkg;

	localparam int WINDOW_SIZE = 65536;
	localparam int WIN_AW      = $clog2(WINDOW_SIZE);
	localparam int OFF_W       = WIN_AW + 1;
	localparam int CMD_DEPTH   = 4;
	localparam int CMD_AW      = $clog2(CMD_DEPTH);

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       block_end;
		logic       block_error;
		logic       run_last;
	} out_item_t;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_TAG,
		PH_EXTRA,
		PH_LITERAL
	} phase_t;

	typedef enum logic [1:0] {
		CMD_LIT,
		CMD_COPY,
		CMD_MARK,
		CMD_ERR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [7:0]         data;
		logic [6:0]         len;
		logic [OFF_W-1:0]   off;
		logic               last;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ISSUE,
		BK_WAIT
	} bk_state_t;

endpackage

FILE: design/snappy_block_decoder_core.sv
// Snappy raw block decoder.
// Input side is a queue write port: one compressed byte per beat, accepted when
// push is high and full is low; is_last marks the final byte of a block.
// Result side is a queue read port: the oldest result sits on out_data while
// empty is low and leaves on a beat with pop high.
// expected_length is written through cfg_valid/cfg_data (cfg_ready is always
// high); the user must do so only while the block is idle, which is not enforced.
// A literal or end marker reaches out_data through the command queue and then
// the result register. Throughput: one input byte per cycle while the command
// queue has room; literals leave at one per cycle while the result register is
// free; the replay engine takes a copy command, then reads and writes each byte.
// A stalled receiver holds the result register, the replay engine waits, the
// four-entry command queue fills and full rises.
// Reset clears parser and queue state and empties the result register; expected_length returns to 0.
// History needs no clearing pass: it is only read where the block wrote it.
// depends on sbd_pkg, sbd_front, sbd_cmd_fifo, sbd_back
module snappy_block_decoder_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  sbd_pkg::in_item_t  in_data,
	output logic               empty,
	input  logic               pop,
	output sbd_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_data
);
	import sbd_pkg::*;

	logic [31:0] expected_length_q;
	logic        accept, f_valid, q_valid, q_pop;
	cmd_t        f_cmd, q_cmd;

	assign accept    = push && !full;
	assign cfg_ready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) expected_length_q <= '0;
		else if (cfg_valid) expected_length_q <= cfg_data;
	end

	sbd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.in_item         (in_data),
		.expected_length (expected_length_q),
		.cmd_valid       (f_valid),
		.cmd             (f_cmd)
	);

	sbd_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (f_valid),
		.wr_cmd   (f_cmd),
		.full     (full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_cmd   (q_cmd)
	);

	sbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.cmd_pop   (q_pop),
		.pop       (pop),
		.empty     (empty),
		.out_data  (out_data)
	);

endmodule

FILE: design/sbd_front.sv
// front end: header and tag parser, turns each compressed byte into at most one command
// depends on sbd_pkg
module sbd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  sbd_pkg::in_item_t in_item,
	input  logic [31:0]     expected_length,
	output logic            cmd_valid,
	output sbd_pkg::cmd_t   cmd
);
	import sbd_pkg::*;

	phase_t      phase_q, phase_n;
	logic [31:0] hv_q, hv_n;
	logic [2:0]  seen_q, seen_n;
	logic [31:0] pc_q, pc_n;
	logic [31:0] lit_left_q, lit_left_n;
	logic [2:0]  extra_left_q, extra_left_n;
	logic [31:0] ev_q, ev_n;
	logic [6:0]  cl_q, cl_n;
	logic [1:0]  kind_q, kind_n;
	logic        failed_q, failed_n;

	logic        err, emit_lit, emit_copy, last;
	logic [7:0]  b;
	logic [38:0] hv_wide;
	logic [5:0]  hv_sh;
	logic [2:0]  total;
	logic [1:0]  idx;
	logic [31:0] room;

	// literal fits in what is left of the block
	function automatic logic lit_ok(input logic [31:0] pc, input logic [31:0] exp_len,
		input logic [31:0] len);
		logic [31:0] r;
		r = exp_len - pc;
		return !(pc > exp_len || len >= r);
	endfunction

	assign b    = in_item.in_byte;
	assign last = in_item.is_last;
	assign room = expected_length - pc_q;

	// parse one byte
	always_comb begin
		phase_n      = phase_q;
		hv_n         = hv_q;
		seen_n       = seen_q;
		pc_n         = pc_q;
		lit_left_n   = lit_left_q;
		extra_left_n = extra_left_q;
		ev_n         = ev_q;
		cl_n         = cl_q;
		kind_n       = kind_q;
		failed_n     = failed_q;
		err          = 1'b0;
		emit_lit     = 1'b0;
		emit_copy    = 1'b0;
		hv_sh        = {3'b000, seen_q} * 6'd7;
		hv_wide      = {7'b0, hv_q} | ({32'b0, b[6:0]} << hv_sh);
		total        = 3'd0;
		idx          = 2'd0;
		cmd_valid    = 1'b0;
		cmd.kind     = CMD_MARK;
		cmd.data     = b;
		cmd.len      = cl_q;
		cmd.off      = ev_q[OFF_W-1:0];
		cmd.last     = last;

		if (accept) begin
			if (failed_q) begin
				if (last) begin
					failed_n = 1'b0;
				end
			end else begin
				case (phase_q)
					PH_HEADER: begin
						if (seen_q >= 3'd4 && b > 8'd15) begin
							err = 1'b1;
						end else begin
							hv_n   = hv_wide[31:0];
							seen_n = seen_q + 3'd1;
							if (!b[7]) begin
								if (hv_wide[31:0] != expected_length) err = 1'b1;
								else phase_n = PH_TAG;
							end
						end
					end
					PH_TAG: begin
						kind_n = b[1:0];
						ev_n   = 32'd0;
						case (b[1:0])
							2'd0: begin
								if (b[7:2] >= 6'd60) begin
									cl_n         = 7'(b[7:2] - 6'd59);
									extra_left_n = 3'(b[7:2] - 6'd59);
									phase_n      = PH_EXTRA;
								end else if (!lit_ok(pc_q, expected_length, {26'b0, b[7:2]})) begin
									err = 1'b1;
								end else begin
									lit_left_n = {26'b0, b[7:2]} + 32'd1;
									phase_n    = PH_LITERAL;
								end
							end
							2'd1: begin
								cl_n         = 7'd4 + {4'b0, b[4:2]};
								ev_n         = {21'b0, b[7:5], 8'b0};
								extra_left_n = 3'd1;
								phase_n      = PH_EXTRA;
							end
							2'd2: begin
								cl_n         = 7'd1 + {1'b0, b[7:2]};
								extra_left_n = 3'd2;
								phase_n      = PH_EXTRA;
							end
							default: begin
								cl_n         = 7'd1 + {1'b0, b[7:2]};
								extra_left_n = 3'd4;
								phase_n      = PH_EXTRA;
							end
						endcase
					end
					PH_EXTRA: begin
						case (kind_q)
							2'd0:    total = cl_q[2:0];
							2'd1:    total = 3'd1;
							2'd2:    total = 3'd2;
							default: total = 3'd4;
						endcase
						idx  = 2'(total - extra_left_q);
						ev_n = ev_q | ({24'b0, b} << {idx, 3'b000});
						if (extra_left_q != 3'd0) extra_left_n = extra_left_q - 3'd1;
						if (extra_left_q <= 3'd1) begin
							if (kind_q == 2'd0) begin
								if (!lit_ok(pc_q, expected_length, ev_n)) begin
									err = 1'b1;
								end else begin
									lit_left_n = ev_n + 32'd1;
									phase_n    = PH_LITERAL;
								end
							end else begin
								if (ev_n == 32'd0 || ev_n > pc_q || ev_n > 32'(WINDOW_SIZE)
									|| pc_q > expected_length || {25'b0, cl_q} > room) begin
									err = 1'b1;
								end else begin
									emit_copy = 1'b1;
									pc_n      = pc_q + {25'b0, cl_q};
									phase_n   = PH_TAG;
								end
							end
						end
					end
					PH_LITERAL: begin
						emit_lit = 1'b1;
						pc_n     = pc_q + 32'd1;
						if (lit_left_q != 32'd0) lit_left_n = lit_left_q - 32'd1;
						if (lit_left_q <= 32'd1) phase_n = PH_TAG;
					end
					default: err = 1'b1;
				endcase

				// final byte must close the block cleanly
				if (!err && last && (phase_n != PH_TAG || pc_n != expected_length)) err = 1'b1;

				cmd_valid = err || emit_lit || emit_copy || last;
				if (err) cmd.kind = CMD_ERR;
				else if (emit_lit) cmd.kind = CMD_LIT;
				else if (emit_copy) cmd.kind = CMD_COPY;
				else cmd.kind = CMD_MARK;
				cmd.off = ev_n[OFF_W-1:0];
				if (err && !last) failed_n = 1'b1;
			end

			// block boundary resets the parser
			if (last) begin
				phase_n      = PH_HEADER;
				hv_n         = 32'd0;
				seen_n       = 3'd0;
				pc_n         = 32'd0;
				lit_left_n   = 32'd0;
				extra_left_n = 3'd0;
				ev_n         = 32'd0;
				cl_n         = 7'd0;
				kind_n       = 2'd0;
				failed_n     = 1'b0;
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			hv_q         <= '0;
			seen_q       <= '0;
			pc_q         <= '0;
			lit_left_q   <= '0;
			extra_left_q <= '0;
			ev_q         <= '0;
			cl_q         <= '0;
			kind_q       <= '0;
			failed_q     <= 1'b0;
		end else begin
			phase_q      <= phase_n;
			hv_q         <= hv_n;
			seen_q       <= seen_n;
			pc_q         <= pc_n;
			lit_left_q   <= lit_left_n;
			extra_left_q <= extra_left_n;
			ev_q         <= ev_n;
			cl_q         <= cl_n;
			kind_q       <= kind_n;
			failed_q     <= failed_n;
		end
	end

endmodule

FILE: design/sbd_cmd_fifo.sv
// short command queue between parser and replay engine
// depends on sbd_pkg
module sbd_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  sbd_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          rd_en,
	output logic          rd_valid,
	output sbd_pkg::cmd_t rd_cmd
);
	import sbd_pkg::*;

	cmd_t          mem_q [CMD_DEPTH];
	logic [CMD_AW-1:0] wp_q, rp_q;
	logic [CMD_AW:0]   cnt_q;

	assign full     = cnt_q == (CMD_AW+1)'(CMD_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_cmd   = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_cmd;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 1'b1;
			if (rd_en) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (CMD_AW+1)'(wr_en) - (CMD_AW+1)'(rd_en);
		end
	end

endmodule

FILE: design/sbd_back.sv
// back end: history memory, copy replay and result register
// depends on sbd_pkg
module sbd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  sbd_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	input  logic               pop,
	output logic               empty,
	output sbd_pkg::out_item_t out_data
);
	import sbd_pkg::*;

	logic [7:0]        hist [WINDOW_SIZE];
	bk_state_t         state_q, state_n;
	logic [WIN_AW-1:0] wp_q, wp_n, src_q, src_n;
	logic [6:0]        left_q, left_n;
	logic [7:0]        rd_q;
	logic              oval_q, oval_n;
	out_item_t         out_q, out_n;
	logic              out_free, wr_en, ld_out, last_b;
	logic [7:0]        wr_data;

	assign out_free = !oval_q || pop;
	assign empty    = !oval_q;
	assign out_data = out_q;
	assign last_b   = left_q == 7'd1;

	// command sequencing
	always_comb begin
		state_n = state_q;
		wp_n    = wp_q;
		src_n   = src_q;
		left_n  = left_q;
		cmd_pop = 1'b0;
		wr_en   = 1'b0;
		wr_data = cmd.data;
		ld_out  = 1'b0;
		out_n   = out_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid && out_free) begin
					case (cmd.kind)
						CMD_LIT: begin
							wr_en   = 1'b1;
							ld_out  = 1'b1;
							out_n   = '{out_byte: cmd.data, byte_valid: 1'b1,
								block_end: cmd.last, block_error: 1'b0, run_last: 1'b1};
							cmd_pop = 1'b1;
							wp_n    = cmd.last ? '0 : wp_q + 1'b1;
						end
						CMD_MARK: begin
							ld_out  = 1'b1;
							out_n   = '{out_byte: 8'd0, byte_valid: 1'b0,
								block_end: 1'b1, block_error: 1'b0, run_last: 1'b1};
							cmd_pop = 1'b1;
							wp_n    = '0;
						end
						CMD_ERR: begin
							ld_out  = 1'b1;
							out_n   = '{out_byte: 8'd0, byte_valid: 1'b0,
								block_end: 1'b1, block_error: 1'b1, run_last: 1'b1};
							cmd_pop = 1'b1;
							wp_n    = '0;
						end
						default: begin
							src_n   = wp_q - cmd.off[WIN_AW-1:0];
							left_n  = cmd.len;
							state_n = BK_ISSUE;
						end
					endcase
				end
			end
			BK_ISSUE: state_n = BK_WAIT;
			BK_WAIT: begin
				if (out_free) begin
					wr_en   = 1'b1;
					wr_data = rd_q;
					ld_out  = 1'b1;
					out_n   = '{out_byte: rd_q, byte_valid: 1'b1,
						block_end: last_b && cmd.last, block_error: 1'b0, run_last: last_b};
					wp_n    = (last_b && cmd.last) ? '0 : wp_q + 1'b1;
					src_n   = src_q + 1'b1;
					left_n  = left_q - 7'd1;
					if (last_b) begin
						cmd_pop = 1'b1;
						state_n = BK_IDLE;
					end else begin
						state_n = BK_ISSUE;
					end
				end
			end
			default: state_n = BK_IDLE;
		endcase
		oval_n = ld_out ? 1'b1 : (pop ? 1'b0 : oval_q);
	end

	// history write port
	always_ff @(posedge clk) begin
		if (wr_en) hist[wp_q] <= wr_data;
	end

	// history read port
	always_ff @(posedge clk) begin
		if (state_q == BK_ISSUE) rd_q <= hist[src_q];
	end

	// result payload
	always_ff @(posedge clk) begin
		if (ld_out) out_q <= out_n;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			wp_q    <= '0;
			src_q   <= '0;
			left_q  <= '0;
			oval_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			wp_q    <= wp_n;
			src_q   <= src_n;
			left_q  <= left_n;
			oval_q  <= oval_n;
		end
	end

endmodule
